>>> design/tgad_pkg.sv
// Shared types and constants for the TGA truecolor to RGBA stream core.
// Used by the front end, the word queue, the back end and the top level.
package tgad_pkg;

    // Header layout
    localparam int HEADER_BYTES = 18;
    localparam int HC_W         = $clog2(HEADER_BYTES + 1);

    localparam logic [HC_W-1:0] HDR_POS_TYPE     = HC_W'(2);
    localparam logic [HC_W-1:0] HDR_POS_WIDTH_LO = HC_W'(12);
    localparam logic [HC_W-1:0] HDR_POS_WIDTH_HI = HC_W'(13);
    localparam logic [HC_W-1:0] HDR_POS_HEIGHT_LO = HC_W'(14);
    localparam logic [HC_W-1:0] HDR_POS_HEIGHT_HI = HC_W'(15);
    localparam logic [HC_W-1:0] HDR_POS_BPP      = HC_W'(16);
    localparam logic [HC_W-1:0] HDR_POS_DESC     = HC_W'(HEADER_BYTES - 1);

    localparam logic [7:0] IMAGE_TYPE_TRUECOLOR = 8'd2;
    localparam logic [4:0] MIN_PIXEL_BYTES      = 5'd3;
    localparam logic [4:0] RGBA_PIXEL_BYTES     = 5'd4;
    localparam logic [7:0] ALPHA_OPAQUE         = 8'd255;
    localparam int         DESC_TOP_DOWN_BIT    = 5;

    // Result codes
    typedef enum logic [1:0] {
        ST_PIXEL     = 2'd0,
        ST_HEADER    = 2'd1,
        ST_BAD_TYPE  = 2'd2,
        ST_BAD_DEPTH = 2'd3
    } status_t;

    // Front end parsing phase
    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_PIXELS = 2'd1,
        PH_IDLE   = 2'd2
    } phase_t;

    // One classified word handed from front end to back end
    typedef struct packed {
        status_t     kind;
        logic [15:0] width;
        logic [15:0] height;
        logic [15:0] column;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic        last;
        logic        row_end;
        logic        top_down;
    } entry_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

>>> design/tgad_front.sv
// Front end: header capture, header checks, pixel byte gathering and
// raster position tracking. Pushes classified words into the queue.
// Depends on tgad_pkg.
module tgad_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_fire,
    input  logic [7:0]      file_byte,
    input  logic            new_file,
    output logic            push,
    output tgad_pkg::entry_t push_entry
);
    import tgad_pkg::*;

    phase_t          phase_reg, phase_next;
    logic [HC_W-1:0] hc_reg, hc_next;
    logic [7:0]      type_reg, type_next;
    logic [15:0]     width_reg, width_next;
    logic [15:0]     height_reg, height_next;
    logic [7:0]      bpp_reg, bpp_next;
    logic [15:0]     column_reg, column_next;
    logic [15:0]     row_reg, row_next;
    logic [4:0]      bip_reg, bip_next;
    logic [7:0]      held_reg [4];
    logic [7:0]      held_next [4];

    phase_t          eff_phase;
    logic [HC_W-1:0] eff_hc;
    logic [4:0]      pixel_bytes;
    logic [16:0]     col_inc;
    logic [16:0]     row_inc;
    logic            pix_last;
    logic            pix_row_end;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            hc_reg     <= '0;
            column_reg <= '0;
            row_reg    <= '0;
            bip_reg    <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            hc_reg     <= hc_next;
            column_reg <= column_next;
            row_reg    <= row_next;
            bip_reg    <= bip_next;
        end
    end

    // Header fields and held channel bytes
    always_ff @(posedge clk)
    begin
        type_reg   <= type_next;
        width_reg  <= width_next;
        height_reg <= height_next;
        bpp_reg    <= bpp_next;
        for (int i = 0; i < 4; i++)
        begin
            held_reg[i] <= held_next[i];
        end
    end

    // A new-file mark restarts header capture with this byte
    assign eff_phase   = new_file ? PH_HEADER : phase_reg;
    assign eff_hc      = new_file ? '0 : hc_reg;
    assign pixel_bytes = bpp_reg[7:3];
    assign col_inc     = {1'b0, column_reg} + 17'd1;
    assign row_inc     = {1'b0, row_reg} + 17'd1;
    assign pix_last    = (col_inc == {1'b0, width_reg}) && (row_inc == {1'b0, height_reg});
    assign pix_row_end = (col_inc >= {1'b0, width_reg});

    // Parse one byte
    always_comb
    begin
        phase_next  = phase_reg;
        hc_next     = hc_reg;
        type_next   = type_reg;
        width_next  = width_reg;
        height_next = height_reg;
        bpp_next    = bpp_reg;
        column_next = column_reg;
        row_next    = row_reg;
        bip_next    = bip_reg;
        for (int i = 0; i < 4; i++)
        begin
            held_next[i] = held_reg[i];
        end
        push       = 1'b0;
        push_entry = '0;

        if (in_fire)
        begin
            phase_next = eff_phase;
            hc_next    = eff_hc;
            unique case (eff_phase)
                PH_HEADER:
                begin
                    hc_next = eff_hc + HC_W'(1);
                    unique case (eff_hc)
                        HDR_POS_TYPE:      type_next = file_byte;
                        HDR_POS_WIDTH_LO:  width_next = {width_reg[15:8], file_byte};
                        HDR_POS_WIDTH_HI:  width_next = {file_byte, width_reg[7:0]};
                        HDR_POS_HEIGHT_LO: height_next = {height_reg[15:8], file_byte};
                        HDR_POS_HEIGHT_HI: height_next = {file_byte, height_reg[7:0]};
                        HDR_POS_BPP:       bpp_next = file_byte;
                        default:           ;
                    endcase
                    // Last header byte is the descriptor: decide now
                    if (eff_hc == HDR_POS_DESC)
                    begin
                        push = 1'b1;
                        if (type_reg != IMAGE_TYPE_TRUECOLOR)
                        begin
                            push_entry.kind = ST_BAD_TYPE;
                            phase_next      = PH_IDLE;
                        end
                        else if (pixel_bytes < MIN_PIXEL_BYTES)
                        begin
                            push_entry.kind = ST_BAD_DEPTH;
                            phase_next      = PH_IDLE;
                        end
                        else
                        begin
                            push_entry.kind     = ST_HEADER;
                            push_entry.width    = width_reg;
                            push_entry.height   = height_reg;
                            push_entry.top_down = file_byte[DESC_TOP_DOWN_BIT];
                            column_next         = '0;
                            row_next            = '0;
                            bip_next            = '0;
                            if (width_reg == '0 || height_reg == '0)
                            begin
                                push_entry.last = 1'b1;
                                phase_next      = PH_IDLE;
                            end
                            else
                            begin
                                phase_next = PH_PIXELS;
                            end
                        end
                    end
                end
                PH_PIXELS:
                begin
                    // Bytes past the fourth of a pixel are dropped
                    for (int i = 0; i < 4; i++)
                    begin
                        if (bip_reg < 5'd4 && bip_reg[1:0] == 2'(i))
                        begin
                            held_next[i] = file_byte;
                        end
                    end
                    if (({1'b0, bip_reg} + 6'd1) < {1'b0, pixel_bytes})
                    begin
                        bip_next = bip_reg + 5'd1;
                    end
                    else
                    begin
                        bip_next           = '0;
                        push               = 1'b1;
                        push_entry.kind    = ST_PIXEL;
                        push_entry.column  = column_reg;
                        push_entry.blue    = held_next[0];
                        push_entry.green   = held_next[1];
                        push_entry.red     = held_next[2];
                        push_entry.alpha   = (pixel_bytes == RGBA_PIXEL_BYTES) ?
                                             held_next[3] : ALPHA_OPAQUE;
                        push_entry.last    = pix_last;
                        push_entry.row_end = pix_row_end;
                        if (pix_last)
                        begin
                            phase_next = PH_IDLE;
                        end
                        else if (pix_row_end)
                        begin
                            column_next = '0;
                            row_next    = row_reg + 16'd1;
                        end
                        else
                        begin
                            column_next = column_reg + 16'd1;
                        end
                    end
                end
                default:
                begin
                    // Error header or finished image: ignore bytes
                end
            endcase
        end
    end

endmodule

>>> design/tgad_queue.sv
// Two-word queue between the front end and the back end.
// Depends on tgad_pkg.
module tgad_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  tgad_pkg::entry_t push_entry,
    input  logic             pop,
    output tgad_pkg::entry_t pop_entry,
    output tgad_pkg::qstat_t stat
);
    import tgad_pkg::*;

    entry_t     slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push;
    logic       do_pop;

    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_entry  = slot_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> design/tgad_back.sv
// Back end: destination index arithmetic and the output register.
// Depends on tgad_pkg.
module tgad_back (
    input  logic             clk,
    input  logic             rst_n,
    input  tgad_pkg::entry_t pop_entry,
    input  tgad_pkg::qstat_t qstat,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [1:0]       status,
    output logic [15:0]      image_width,
    output logic [15:0]      image_height,
    output logic [31:0]      pixel_index,
    output logic [7:0]       red,
    output logic [7:0]       green,
    output logic [7:0]       blue,
    output logic [7:0]       alpha,
    output logic             last_pixel
);
    import tgad_pkg::*;

    logic        valid_reg, valid_next;
    logic [31:0] row_base_reg, row_base_next;
    logic [15:0] stride_reg, stride_next;
    logic        top_down_reg, top_down_next;
    logic [1:0]  status_reg;
    logic [15:0] width_out_reg, height_out_reg;
    logic [31:0] index_reg;
    logic [7:0]  red_reg, green_reg, blue_reg, alpha_reg;
    logic        last_reg;

    logic [15:0] height_m1;
    logic [31:0] bottom_base;

    assign pop        = !qstat.empty && (!valid_reg || out_ready);
    assign height_m1  = pop_entry.height - 16'd1;
    assign bottom_base = 32'(height_m1) * 32'(pop_entry.width);

    // Row base tracking; flipped images start at the bottom row
    always_comb
    begin
        valid_next    = valid_reg;
        row_base_next = row_base_reg;
        stride_next   = stride_reg;
        top_down_next = top_down_reg;
        if (valid_reg && out_ready)
        begin
            valid_next = 1'b0;
        end
        if (pop)
        begin
            valid_next = 1'b1;
            if (pop_entry.kind == ST_HEADER)
            begin
                stride_next   = pop_entry.width;
                top_down_next = pop_entry.top_down;
                row_base_next = pop_entry.top_down ? '0 : bottom_base;
            end
            else if (pop_entry.kind == ST_PIXEL && pop_entry.row_end)
            begin
                row_base_next = top_down_reg ? row_base_reg + 32'(stride_reg)
                                             : row_base_reg - 32'(stride_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            row_base_reg <= '0;
            stride_reg   <= '0;
            top_down_reg <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            row_base_reg <= row_base_next;
            stride_reg   <= stride_next;
            top_down_reg <= top_down_next;
        end
    end

    // Output word register
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            status_reg     <= pop_entry.kind;
            width_out_reg  <= pop_entry.width;
            height_out_reg <= pop_entry.height;
            index_reg      <= (pop_entry.kind == ST_PIXEL) ?
                              row_base_reg + 32'(pop_entry.column) : '0;
            red_reg        <= pop_entry.red;
            green_reg      <= pop_entry.green;
            blue_reg       <= pop_entry.blue;
            alpha_reg      <= pop_entry.alpha;
            last_reg       <= pop_entry.last;
        end
    end

    assign out_valid    = valid_reg;
    assign status       = status_reg;
    assign image_width  = width_out_reg;
    assign image_height = height_out_reg;
    assign pixel_index  = index_reg;
    assign red          = red_reg;
    assign green        = green_reg;
    assign blue         = blue_reg;
    assign alpha        = alpha_reg;
    assign last_pixel   = last_reg;

endmodule

>>> design/tga_truecolor_to_rgba_stream_core.sv
// TGA uncompressed truecolor decoder: one file byte in, header and pixel words out.
// Each word passes through the queue and then the output register before it leaves.
// Takes one byte per cycle while the queue is not full; a pixel word is pushed on its last byte.
// The two-word queue lets byte intake run while the output is stalled.
// Reset (rst_n, async, active low) empties queue and output and starts header capture.
// Depends on tgad_pkg, tgad_front, tgad_queue and tgad_back.
module tga_truecolor_to_rgba_stream_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  file_byte,
    input  logic        new_file,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [15:0] image_width,
    output logic [15:0] image_height,
    output logic [31:0] pixel_index,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic [7:0]  alpha,
    output logic        last_pixel
);
    import tgad_pkg::*;

    logic   in_fire;
    logic   push;
    logic   pop;
    entry_t push_entry;
    entry_t pop_entry;
    qstat_t qstat;

    // Accept a byte whenever the queue has room for the word it may produce
    assign in_ready = !qstat.full;
    assign in_fire  = in_valid && in_ready;

    tgad_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_fire    (in_fire),
        .file_byte  (file_byte),
        .new_file   (new_file),
        .push       (push),
        .push_entry (push_entry)
    );

    tgad_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .stat       (qstat)
    );

    tgad_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_entry    (pop_entry),
        .qstat        (qstat),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .image_width  (image_width),
        .image_height (image_height),
        .pixel_index  (pixel_index),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .alpha        (alpha),
        .last_pixel   (last_pixel)
    );

`ifndef SYNTHESIS
    // Queue cannot report full and empty together
    assert property (@(posedge clk) disable iff (!rst_n) !(qstat.full && qstat.empty))
        else $error("queue full and empty at once");

    // A pop into the output register shows up as a valid word next cycle
    assert property (@(posedge clk) disable iff (!rst_n) pop |=> out_valid)
        else $error("popped word not presented");

    // Error headers never report a size or end an image
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_BAD_TYPE || status == ST_BAD_DEPTH) |->
        image_width == 16'd0 && image_height == 16'd0 && !last_pixel)
        else $error("error header carries size or last flag");

    // Pixel words carry no header size
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_PIXEL |-> image_width == 16'd0 && image_height == 16'd0)
        else $error("pixel word carries header size");
`endif

endmodule
